// ===== rtl/brtd_pkg.sv =====
// shared types, constants and the degree-to-angle table for the drive controller
`default_nettype none

package brtd_pkg;

  // binary angle width: a full circle is 2**ANGLE_BITS units
  localparam int ANGLE_BITS = 16;
  // compare width for heading error against the 15-bit tolerance
  localparam int CMP_W = (ANGLE_BITS > 15) ? ANGLE_BITS : 15;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // drive commands
  localparam logic signed [8:0]  LIN_REVERSE = -9'sd150;
  localparam logic signed [8:0]  LIN_FORWARD = 9'sd200;
  localparam logic signed [10:0] TURN_RATE   = 11'sd785;
  localparam logic signed [20:0] WALL_CLAMP  = 21'sd500;

  // turn angle offsets in degrees
  localparam logic [6:0] SIDE_DEG_BASE  = 7'd5;
  localparam logic [6:0] FRONT_DEG_BASE = 7'd30;

  // reciprocals for the random reductions (exact over 16-bit inputs)
  localparam logic [15:0] RECIP_11 = 16'd47663;  // ceil(2**19 / 11)
  localparam int          SHIFT_11 = 19;
  localparam logic [16:0] RECIP_91 = 17'd92183;  // ceil(2**23 / 91)
  localparam int          SHIFT_91 = 23;

  typedef enum logic [1:0] {
    MODE_FWD  = 2'd0,
    MODE_REV  = 2'd1,
    MODE_TURN = 2'd2,
    MODE_HALT = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    BK_NONE    = 3'd0,
    BK_SIDE_L  = 3'd1,
    BK_SIDE_R  = 3'd2,
    BK_FRONT_L = 3'd3,
    BK_FRONT_R = 3'd4,
    BK_FRONT_C = 3'd5
  } bump_kind_t;

  typedef enum logic [2:0] {
    REG_DESIRED_WALL  = 3'd0,
    REG_WALL_GAIN     = 3'd1,
    REG_WALL_DETECT   = 3'd2,
    REG_OBSTACLE      = 3'd3,
    REG_REVERSE_TICKS = 3'd4,
    REG_RUN_TICKS     = 3'd5,
    REG_YAW_TOL       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [11:0] desired_wall_mm;
    logic [9:0]  wall_gain_q8;
    logic [12:0] wall_detect_mm;
    logic [12:0] obstacle_mm;
    logic [7:0]  reverse_ticks;
    logic [15:0] run_ticks;
    logic [14:0] yaw_tolerance;
  } cfg_t;

  // one tick after ingress preprocessing
  typedef struct packed {
    logic                   any_bump;
    bump_kind_t             bump_kind;
    logic [ANGLE_BITS-1:0]  heading;
    logic [3:0]             rnd_mod11;
    logic [6:0]             rnd_mod91;
    logic                   rside_right;
    logic                   away_left;
    logic                   obstacle;
    logic                   wall_near;
    logic signed [10:0]     wall_ang;
  } stage_t;

  typedef struct packed {
    logic halted;
    logic reversing;
    logic turning;
  } status_t;

  // degrees to binary angle, rounded to nearest, ties up
  localparam int DEG_TBL_DEPTH = 128;
  typedef logic [ANGLE_BITS-1:0] deg_tbl_t [0:DEG_TBL_DEPTH-1];

  function automatic deg_tbl_t build_deg_tbl();
    deg_tbl_t tbl;
    for (int i = 0; i < DEG_TBL_DEPTH; i++) begin
      tbl[i] = ANGLE_BITS'(((64'(i) << ANGLE_BITS) + 64'd180) / 64'd360);
    end
    return tbl;
  endfunction

  localparam deg_tbl_t DEG_TBL = build_deg_tbl();

endpackage

`default_nettype wire

// ===== rtl/brtd_in_if.sv =====
// input channel: one control tick per beat
`default_nettype none

interface brtd_in_if;
  logic               valid;
  logic               ready;
  logic               bump_side_left;
  logic               bump_side_right;
  logic               bump_fore_left;
  logic               bump_fore_right;
  logic               bump_fore_center;
  logic signed [15:0] heading;
  logic [15:0]        front_min_mm;
  logic [15:0]        left_side_mm;
  logic [15:0]        right_side_mm;
  logic [15:0]        right_wall_mm;
  logic [15:0]        random_angle;
  logic               random_side;

  modport source (
    output valid, bump_side_left, bump_side_right, bump_fore_left, bump_fore_right,
           bump_fore_center, heading, front_min_mm, left_side_mm, right_side_mm,
           right_wall_mm, random_angle, random_side,
    input  ready
  );

  modport sink (
    input  valid, bump_side_left, bump_side_right, bump_fore_left, bump_fore_right,
           bump_fore_center, heading, front_min_mm, left_side_mm, right_side_mm,
           right_wall_mm, random_angle, random_side,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/brtd_out_if.sv =====
// result channel: one drive command per beat
`default_nettype none

interface brtd_out_if;
  logic               valid;
  logic               ready;
  logic signed [8:0]  linear_mm_s;
  logic signed [10:0] angular_mrad_s;
  logic [1:0]         mode;

  modport source (
    output valid, linear_mm_s, angular_mrad_s, mode,
    input  ready
  );

  modport sink (
    input  valid, linear_mm_s, angular_mrad_s, mode,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/brtd_cfg_regs.sv =====
// apb configuration registers
`default_nettype none

module brtd_cfg_regs
  import brtd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  logic wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.desired_wall_mm <= 12'd600;
      cfg_r.wall_gain_q8    <= 10'd205;
      cfg_r.wall_detect_mm  <= 13'd1000;
      cfg_r.obstacle_mm     <= 13'd500;
      cfg_r.reverse_ticks   <= 8'd5;
      cfg_r.run_ticks       <= 16'd4800;
      cfg_r.yaw_tolerance   <= 15'd1043;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DESIRED_WALL:  cfg_r.desired_wall_mm <= pwdata[11:0];
        REG_WALL_GAIN:     cfg_r.wall_gain_q8    <= pwdata[9:0];
        REG_WALL_DETECT:   cfg_r.wall_detect_mm  <= pwdata[12:0];
        REG_OBSTACLE:      cfg_r.obstacle_mm     <= pwdata[12:0];
        REG_REVERSE_TICKS: cfg_r.reverse_ticks   <= pwdata[7:0];
        REG_RUN_TICKS:     cfg_r.run_ticks       <= pwdata[15:0];
        REG_YAW_TOL:       cfg_r.yaw_tolerance   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_DESIRED_WALL:  prdata = CFG_DATA_W'(cfg_r.desired_wall_mm);
      REG_WALL_GAIN:     prdata = CFG_DATA_W'(cfg_r.wall_gain_q8);
      REG_WALL_DETECT:   prdata = CFG_DATA_W'(cfg_r.wall_detect_mm);
      REG_OBSTACLE:      prdata = CFG_DATA_W'(cfg_r.obstacle_mm);
      REG_REVERSE_TICKS: prdata = CFG_DATA_W'(cfg_r.reverse_ticks);
      REG_RUN_TICKS:     prdata = CFG_DATA_W'(cfg_r.run_ticks);
      REG_YAW_TOL:       prdata = CFG_DATA_W'(cfg_r.yaw_tolerance);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/brtd_ingress.sv =====
// input register with state-independent preprocessing of each tick
`default_nettype none

module brtd_ingress
  import brtd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  brtd_in_if.sink   in_ch,
  input  cfg_t      cfg,
  input  wire logic take,
  output logic      stage_valid,
  output stage_t    stage
);

  logic       stage_valid_r;
  stage_t     stage_r;
  stage_t     stage_nxt;
  logic       accept;

  logic [31:0]        prod11;
  logic [12:0]        q11;
  logic [32:0]        prod91;
  logic [9:0]         q91;
  logic signed [16:0] wall_err;
  logic signed [27:0] wall_prod;
  logic signed [28:0] wall_sum;
  logic signed [20:0] wall_q;

  assign in_ch.ready = !stage_valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign stage_valid = stage_valid_r;
  assign stage       = stage_r;

  // random reductions by reciprocal multiply
  assign prod11 = in_ch.random_angle * RECIP_11;
  assign q11    = prod11[SHIFT_11 +: 13];
  assign prod91 = {1'b0, in_ch.random_angle} * {16'd0, RECIP_91};
  assign q91    = prod91[SHIFT_91 +: 10];

  // proportional wall term, floor((-gain * err + 128) / 256)
  assign wall_err  = $signed({1'b0, in_ch.right_wall_mm}) -
                     $signed({5'd0, cfg.desired_wall_mm});
  assign wall_prod = $signed({1'b0, cfg.wall_gain_q8}) * wall_err;
  assign wall_sum  = 29'sd128 - 29'(wall_prod);
  assign wall_q    = 21'(wall_sum >>> 8);

  always_comb begin
    stage_nxt.any_bump = in_ch.bump_side_left | in_ch.bump_side_right |
                         in_ch.bump_fore_left | in_ch.bump_fore_right |
                         in_ch.bump_fore_center;
    // first pressed bumper wins
    if (in_ch.bump_side_left)       stage_nxt.bump_kind = BK_SIDE_L;
    else if (in_ch.bump_side_right) stage_nxt.bump_kind = BK_SIDE_R;
    else if (in_ch.bump_fore_left)  stage_nxt.bump_kind = BK_FRONT_L;
    else if (in_ch.bump_fore_right) stage_nxt.bump_kind = BK_FRONT_R;
    else                            stage_nxt.bump_kind = BK_FRONT_C;

    stage_nxt.heading     = ANGLE_BITS'(in_ch.heading);
    stage_nxt.rnd_mod11   = 4'(in_ch.random_angle - ({3'd0, q11} * 16'd11));
    stage_nxt.rnd_mod91   = 7'(in_ch.random_angle - ({6'd0, q91} * 16'd91));
    stage_nxt.rside_right = in_ch.random_side;
    stage_nxt.away_left   = !(in_ch.left_side_mm < in_ch.right_side_mm);
    stage_nxt.obstacle    = in_ch.front_min_mm < {3'd0, cfg.obstacle_mm};
    stage_nxt.wall_near   = in_ch.right_wall_mm < {3'd0, cfg.wall_detect_mm};

    // clamp to the steering limit
    if (wall_q > WALL_CLAMP)       stage_nxt.wall_ang = 11'(WALL_CLAMP);
    else if (wall_q < -WALL_CLAMP) stage_nxt.wall_ang = 11'(-WALL_CLAMP);
    else                           stage_nxt.wall_ang = 11'(wall_q);
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (accept) begin
      stage_valid_r <= 1'b1;
    end else if (take) begin
      stage_valid_r <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brtd_core.sv =====
// drive decision, controller state and result register
`default_nettype none

module brtd_core
  import brtd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  cfg_t      cfg,
  input  wire logic stage_valid,
  input  stage_t    stage,
  output logic      take,
  output status_t   status,
  brtd_out_if.source out_ch
);

  // controller state
  logic                  halted_r,    halted_nxt;
  logic                  reversing_r, reversing_nxt;
  logic                  turning_r,   turning_nxt;
  logic                  turn_left_r, turn_left_nxt;
  logic [15:0]           tick_r,      tick_nxt;
  logic [7:0]            rev_cnt_r,   rev_cnt_nxt;
  bump_kind_t            kind_r,      kind_nxt;
  logic [ANGLE_BITS-1:0] target_r,    target_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [8:0]  lin_r,  lin_nxt;
  logic signed [10:0] ang_r,  ang_nxt;
  mode_t              mode_r, mode_nxt;

  // turn start helpers
  logic                  kind_left;
  logic                  kind_side;
  logic                  start_left;
  logic                  start_side;
  logic [6:0]            deg;
  logic [ANGLE_BITS-1:0] delta;
  logic [ANGLE_BITS-1:0] start_target;
  logic [ANGLE_BITS-1:0] diff;
  logic [ANGLE_BITS-1:0] mag;
  logic                  on_heading;
  logic [7:0]            rev_cnt_inc;

  assign take   = stage_valid && (!out_valid_r || out_ch.ready);
  assign status = '{halted: halted_r, reversing: reversing_r, turning: turning_r};

  assign out_ch.valid          = out_valid_r;
  assign out_ch.linear_mm_s    = lin_r;
  assign out_ch.angular_mrad_s = ang_r;
  assign out_ch.mode           = mode_r;

  // direction and angle class from the bumper that was hit
  always_comb begin
    case (kind_r)
      BK_SIDE_L: begin
        kind_left = 1'b0;
        kind_side = 1'b1;
      end
      BK_SIDE_R: begin
        kind_left = 1'b1;
        kind_side = 1'b1;
      end
      BK_FRONT_L: begin
        kind_left = 1'b0;
        kind_side = 1'b0;
      end
      BK_FRONT_R: begin
        kind_left = 1'b1;
        kind_side = 1'b0;
      end
      BK_FRONT_C: begin
        kind_left = stage.away_left;
        kind_side = 1'b0;
      end
      default: begin
        kind_left = !stage.rside_right;
        kind_side = 1'b0;
      end
    endcase
  end

  // new turn target, from a bump after reversing or from an obstacle
  assign start_left   = reversing_r ? kind_left : stage.away_left;
  assign start_side   = reversing_r && kind_side;
  assign deg          = start_side ? (SIDE_DEG_BASE + {3'd0, stage.rnd_mod11})
                                   : (FRONT_DEG_BASE + stage.rnd_mod91);
  assign delta        = DEG_TBL[deg];
  assign start_target = start_left ? (stage.heading + delta) : (stage.heading - delta);

  // heading error magnitude, half circle counts as half circle
  assign diff       = target_r - stage.heading;
  assign mag        = diff[ANGLE_BITS-1] ? (~diff + 1'b1) : diff;
  assign on_heading = CMP_W'(mag) < CMP_W'(cfg.yaw_tolerance);

  assign rev_cnt_inc = (rev_cnt_r == 8'hFF) ? rev_cnt_r : (rev_cnt_r + 8'd1);

  always_comb begin
    halted_nxt    = halted_r;
    reversing_nxt = reversing_r;
    turning_nxt   = turning_r;
    turn_left_nxt = turn_left_r;
    tick_nxt      = tick_r;
    rev_cnt_nxt   = rev_cnt_r;
    kind_nxt      = kind_r;
    target_nxt    = target_r;
    lin_nxt       = '0;
    ang_nxt       = '0;
    mode_nxt      = MODE_FWD;

    if (halted_r || (tick_r >= cfg.run_ticks)) begin
      halted_nxt = 1'b1;
      mode_nxt   = MODE_HALT;
    end else begin
      tick_nxt = tick_r + 16'd1;
      if (stage.any_bump && !reversing_r) begin
        // new bump starts a reverse
        reversing_nxt = 1'b1;
        rev_cnt_nxt   = '0;
        turning_nxt   = 1'b0;
        kind_nxt      = stage.bump_kind;
        lin_nxt       = LIN_REVERSE;
        mode_nxt      = MODE_REV;
      end else if (reversing_r) begin
        rev_cnt_nxt = rev_cnt_inc;
        if (rev_cnt_inc < cfg.reverse_ticks) begin
          lin_nxt  = LIN_REVERSE;
          mode_nxt = MODE_REV;
        end else begin
          // reverse done, turn away
          reversing_nxt = 1'b0;
          turning_nxt   = 1'b1;
          turn_left_nxt = start_left;
          target_nxt    = start_target;
          ang_nxt       = start_left ? TURN_RATE : -TURN_RATE;
          mode_nxt      = MODE_TURN;
        end
      end else if (turning_r) begin
        if (on_heading) begin
          turning_nxt = 1'b0;
          lin_nxt     = LIN_FORWARD;
        end else begin
          ang_nxt  = turn_left_r ? TURN_RATE : -TURN_RATE;
          mode_nxt = MODE_TURN;
        end
      end else if (stage.obstacle) begin
        turning_nxt   = 1'b1;
        turn_left_nxt = start_left;
        target_nxt    = start_target;
        ang_nxt       = start_left ? TURN_RATE : -TURN_RATE;
        mode_nxt      = MODE_TURN;
      end else begin
        lin_nxt = LIN_FORWARD;
        ang_nxt = stage.wall_near ? stage.wall_ang : 11'sd0;
      end
    end
  end

  // result valid
  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r    <= 1'b0;
      reversing_r <= 1'b0;
      turning_r   <= 1'b0;
      turn_left_r <= 1'b1;
      tick_r      <= '0;
      rev_cnt_r   <= '0;
      kind_r      <= BK_NONE;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        halted_r    <= halted_nxt;
        reversing_r <= reversing_nxt;
        turning_r   <= turning_nxt;
        turn_left_r <= turn_left_nxt;
        tick_r      <= tick_nxt;
        rev_cnt_r   <= rev_cnt_nxt;
        kind_r      <= kind_nxt;
        target_r    <= target_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      lin_r  <= lin_nxt;
      ang_r  <= ang_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bump_reverse_turn_drive_controller.sv =====
// top level of the bump, reverse and turn drive controller
`default_nettype none

// Each input beat is one control tick and yields exactly one drive command
// beat (linear speed, turn rate, mode). The block takes one tick per clock
// cycle while the result side is not stalled. The tick lands in an input
// register, where the random reductions and the wall-following term are
// prepared; the decision and controller state update then fill the result
// register, from which the command is presented. A stalled result holds the
// input register, so at most one more tick is accepted behind it.
// Configuration is written over the APB port at byte address 4*index; reset
// brings every configuration register to its default and the controller to
// forward. Once the run limit is reached the block reports halted until
// reset.
module bump_reverse_turn_drive_controller
  import brtd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  brtd_in_if.sink                    in_ch,
  brtd_out_if.source                 out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t    cfg;
  stage_t  stage;
  logic    stage_valid;
  logic    take;
  status_t status;

  // configuration registers
  brtd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input register
  brtd_ingress u_ingress (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg         (cfg),
    .take        (take),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  // decision and result register
  brtd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .stage_valid (stage_valid),
    .stage       (stage),
    .take        (take),
    .status      (status),
    .out_ch      (out_ch)
  );

  // halt is sticky until reset
  a_halt_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    status.halted |=> status.halted)
    else $error("halt state cleared without reset");

  // never reversing and turning at once
  a_rev_turn_excl : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({status.reversing, status.turning}))
    else $error("reversing and turning both set");

  // a halted command beat implies the halt state
  a_halt_mode : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.mode == MODE_HALT)) |-> status.halted)
    else $error("halted mode reported while not halted");

  // a turn beat carries full turn rate and no forward speed
  a_turn_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.mode == MODE_TURN)) |->
      ((out_ch.linear_mm_s == 9'sd0) &&
       ((out_ch.angular_mrad_s == TURN_RATE) || (out_ch.angular_mrad_s == -TURN_RATE))))
    else $error("turn beat with wrong command");

endmodule

`default_nettype wire

// ===== tb/sv/bump_reverse_turn_drive_controller_test.sv =====
// self-checking testbench for the bump, reverse and turn drive controller
`default_nettype none

module bump_reverse_turn_drive_controller_test;
  import brtd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LATENCY     = 4;

  localparam logic signed [8:0]  REV_SPEED   = -9'sd150;
  localparam logic signed [8:0]  FWD_SPEED   = 9'sd200;
  localparam logic signed [10:0] TURN_SPEED  = 11'sd785;
  localparam longint             STEER_LIMIT = 500;

  // one control tick; bumps: side left, side right, front left, front right, front center
  typedef struct {
    logic [4:0]         bumps;
    logic signed [15:0] heading;
    logic [15:0]        front_min_mm;
    logic [15:0]        left_side_mm;
    logic [15:0]        right_side_mm;
    logic [15:0]        right_wall_mm;
    logic [15:0]        random_angle;
    logic               random_side;
  } tick_t;

  typedef struct {
    logic signed [8:0]  linear_mm_s;
    logic signed [10:0] angular_mrad_s;
    mode_t              mode;
  } drive_cmd_t;

  typedef struct {
    logic        reversing;
    logic        turning;
    logic        halted;
    logic        turn_left;
    logic [15:0] tick_count;
    logic [7:0]  rev_count;
    bump_kind_t  bump_kind;
    logic [15:0] target_heading;
  } ctl_state_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  brtd_in_if  in_ch ();
  brtd_out_if out_ch ();

  bump_reverse_turn_drive_controller u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  tick_t      pending_ticks[$];
  drive_cmd_t expected_cmds[$];
  tick_t      driven_tick;
  ctl_state_t model_state;
  ctl_state_t lookahead_state;
  cfg_t       model_cfg;
  logic [15:0] gen_heading;
  int send_idle_pct;
  int recv_stall_pct;
  int err_count;
  int ticks_sent;
  int cycle_count;
  int mode_seen[4];

  function automatic ctl_state_t ctl_reset();
    ctl_state_t s;
    s.reversing      = 1'b0;
    s.turning        = 1'b0;
    s.halted         = 1'b0;
    s.turn_left      = 1'b1;
    s.tick_count     = '0;
    s.rev_count      = '0;
    s.bump_kind      = BK_NONE;
    s.target_heading = '0;
    return s;
  endfunction

  // aim the turn deg degrees left or right of the current heading
  function automatic void begin_turn(inout ctl_state_t s, input logic [15:0] hdg,
                                     input logic left, input int unsigned deg);
    logic [15:0] span;
    span = 16'(((deg << 16) + 180) / 360);
    s.turn_left      = left;
    s.target_heading = left ? hdg + span : hdg - span;
    s.turning        = 1'b1;
  endfunction

  // next drive command for one tick, advancing the controller state
  function automatic drive_cmd_t predict_drive(inout ctl_state_t s, input tick_t t,
                                               input cfg_t c);
    drive_cmd_t  r;
    logic        away_left;
    logic [15:0] diff;
    int          mag;
    longint      steer;
    r.linear_mm_s    = '0;
    r.angular_mrad_s = '0;
    r.mode           = MODE_FWD;
    away_left = !(t.left_side_mm < t.right_side_mm);

    // run limit: halted for good
    if (s.halted || s.tick_count >= c.run_ticks) begin
      s.halted = 1'b1;
      r.mode   = MODE_HALT;
      return r;
    end
    s.tick_count = s.tick_count + 16'd1;

    // fresh bump starts a reverse, bumps during a reverse are ignored
    if (t.bumps != 5'd0 && !s.reversing) begin
      s.reversing = 1'b1;
      s.rev_count = '0;
      s.turning   = 1'b0;
      if (t.bumps[0])      s.bump_kind = BK_SIDE_L;
      else if (t.bumps[1]) s.bump_kind = BK_SIDE_R;
      else if (t.bumps[2]) s.bump_kind = BK_FRONT_L;
      else if (t.bumps[3]) s.bump_kind = BK_FRONT_R;
      else                 s.bump_kind = BK_FRONT_C;
      r.linear_mm_s = REV_SPEED;
      r.mode        = MODE_REV;
      return r;
    end

    // reverse countdown, the last tick already turns
    if (s.reversing) begin
      if (s.rev_count != 8'hff) s.rev_count = s.rev_count + 8'd1;
      if (s.rev_count < c.reverse_ticks) begin
        r.linear_mm_s = REV_SPEED;
        r.mode        = MODE_REV;
        return r;
      end
      s.reversing = 1'b0;
      case (s.bump_kind)
        BK_SIDE_L:  begin_turn(s, t.heading, 1'b0, 5 + t.random_angle % 11);
        BK_SIDE_R:  begin_turn(s, t.heading, 1'b1, 5 + t.random_angle % 11);
        BK_FRONT_L: begin_turn(s, t.heading, 1'b0, 30 + t.random_angle % 91);
        BK_FRONT_R: begin_turn(s, t.heading, 1'b1, 30 + t.random_angle % 91);
        BK_FRONT_C: begin_turn(s, t.heading, away_left, 30 + t.random_angle % 91);
        default:    begin_turn(s, t.heading, !t.random_side, 30 + t.random_angle % 91);
      endcase
      r.angular_mrad_s = s.turn_left ? TURN_SPEED : -TURN_SPEED;
      r.mode           = MODE_TURN;
      return r;
    end

    // turn until the heading error drops under the tolerance
    if (s.turning) begin
      diff = s.target_heading - t.heading;
      mag  = (diff >= 16'h8000) ? 65536 - int'(diff) : int'(diff);
      if (mag < int'(c.yaw_tolerance)) begin
        s.turning     = 1'b0;
        r.linear_mm_s = FWD_SPEED;
        return r;
      end
      r.angular_mrad_s = s.turn_left ? TURN_SPEED : -TURN_SPEED;
      r.mode           = MODE_TURN;
      return r;
    end

    // obstacle ahead: turn away from the nearer side
    if (t.front_min_mm < c.obstacle_mm) begin
      begin_turn(s, t.heading, away_left, 30 + t.random_angle % 91);
      r.angular_mrad_s = s.turn_left ? TURN_SPEED : -TURN_SPEED;
      r.mode           = MODE_TURN;
      return r;
    end

    // forward with clamped right-wall following
    r.linear_mm_s = FWD_SPEED;
    if (t.right_wall_mm < c.wall_detect_mm) begin
      steer = (longint'(c.wall_gain_q8) *
               (longint'(c.desired_wall_mm) - longint'(t.right_wall_mm)) + 128) >>> 8;
      if (steer > STEER_LIMIT)  steer = STEER_LIMIT;
      if (steer < -STEER_LIMIT) steer = -STEER_LIMIT;
      r.angular_mrad_s = 11'(steer);
    end
    return r;
  endfunction

  function automatic tick_t quiet_tick(logic [15:0] hdg);
    tick_t t;
    t.bumps         = '0;
    t.heading       = hdg;
    t.front_min_mm  = 16'hffff;
    t.left_side_mm  = 16'hffff;
    t.right_side_mm = 16'hffff;
    t.right_wall_mm = 16'hffff;
    t.random_angle  = '0;
    t.random_side   = 1'b0;
    return t;
  endfunction

  // queue a tick, tracking where the controller will be once it is taken
  task automatic add_tick(tick_t t);
    void'(predict_drive(lookahead_state, t, model_cfg));
    pending_ticks.push_back(t);
  endtask

  // mostly plausible motion: heading steers toward an active turn target
  task automatic add_random_tick();
    tick_t t;
    int    err;
    int    step;
    int    w;
    int    pick;
    if (lookahead_state.turning) begin
      err  = int'($signed(lookahead_state.target_heading - gen_heading));
      step = $urandom_range(4000, 50);
      if (err > step)       gen_heading = gen_heading + 16'(step);
      else if (err < -step) gen_heading = gen_heading - 16'(step);
      else gen_heading = lookahead_state.target_heading + 16'($urandom_range(64)) - 16'd32;
    end else begin
      gen_heading = gen_heading + 16'($urandom_range(400)) - 16'd200;
    end
    if ($urandom_range(19) == 0) gen_heading = 16'($urandom);
    t = quiet_tick(gen_heading);

    case ($urandom_range(9))
      0, 1:    t.front_min_mm = (model_cfg.obstacle_mm == 0) ? 16'd0 :
                                16'($urandom_range(model_cfg.obstacle_mm - 13'd1));
      2:       t.front_min_mm = 16'hffff;
      default: t.front_min_mm = 16'($urandom_range(65535, model_cfg.obstacle_mm));
    endcase
    t.left_side_mm  = 16'($urandom);
    t.right_side_mm = ($urandom_range(4) == 0) ? t.left_side_mm : 16'($urandom);
    if ($urandom_range(9) == 0) t.left_side_mm = 16'hffff;
    if ($urandom_range(9) == 0) t.right_side_mm = 16'hffff;
    case ($urandom_range(9))
      0:       t.right_wall_mm = 16'hffff;
      1:       t.right_wall_mm = 16'($urandom);
      default: begin
        w = int'(model_cfg.desired_wall_mm) + $urandom_range(2000) - 1000;
        if (w < 0) w = 0;
        t.right_wall_mm = 16'(w);
      end
    endcase
    t.random_angle = 16'($urandom);
    t.random_side  = 1'($urandom);

    pick = $urandom_range(99);
    if (pick < 3)      t.bumps = 5'($urandom_range(31, 1));
    else if (pick < 6) t.bumps = 5'd1 << $urandom_range(4);

    // noise beat: every field anywhere in its range
    if ($urandom_range(99) < 8) begin
      t.bumps         = ($urandom_range(3) == 0) ? 5'($urandom) : 5'd0;
      t.heading       = 16'($urandom);
      t.front_min_mm  = 16'($urandom);
      t.left_side_mm  = 16'($urandom);
      t.right_side_mm = 16'($urandom);
      t.right_wall_mm = 16'($urandom);
    end
    add_tick(t);
  endtask

  // wait until the block has returned every command
  task automatic drain();
    while (pending_ticks.size() != 0 || in_ch.valid || expected_cmds.size() != 0)
      @(negedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_DESIRED_WALL:  model_cfg.desired_wall_mm = val[11:0];
      REG_WALL_GAIN:     model_cfg.wall_gain_q8    = val[9:0];
      REG_WALL_DETECT:   model_cfg.wall_detect_mm  = val[12:0];
      REG_OBSTACLE:      model_cfg.obstacle_mm     = val[12:0];
      REG_REVERSE_TICKS: model_cfg.reverse_ticks   = val[7:0];
      REG_RUN_TICKS:     model_cfg.run_ticks       = val[15:0];
      REG_YAW_TOL:       model_cfg.yaw_tolerance   = val[14:0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(int dw, int gain, int detect, int obst, int rev, int run,
                           int yaw);
    write_reg(REG_DESIRED_WALL, dw);
    write_reg(REG_WALL_GAIN, gain);
    write_reg(REG_WALL_DETECT, detect);
    write_reg(REG_OBSTACLE, obst);
    write_reg(REG_REVERSE_TICKS, rev);
    write_reg(REG_RUN_TICKS, run);
    write_reg(REG_YAW_TOL, yaw);
  endtask

  task automatic run_phase(int n, int s_idle, int r_stall);
    lookahead_state = model_state;
    send_idle_pct   = s_idle;
    recv_stall_pct  = r_stall;
    repeat (n) add_random_tick();
    drain();
  endtask

  // driver: one tick per beat, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_cmds.push_back(predict_drive(model_state, driven_tick, model_cfg));
        ticks_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_tick = pending_ticks.pop_front();
          in_ch.bump_side_left   <= driven_tick.bumps[0];
          in_ch.bump_side_right  <= driven_tick.bumps[1];
          in_ch.bump_fore_left   <= driven_tick.bumps[2];
          in_ch.bump_fore_right  <= driven_tick.bumps[3];
          in_ch.bump_fore_center <= driven_tick.bumps[4];
          in_ch.heading          <= driven_tick.heading;
          in_ch.front_min_mm     <= driven_tick.front_min_mm;
          in_ch.left_side_mm     <= driven_tick.left_side_mm;
          in_ch.right_side_mm    <= driven_tick.right_side_mm;
          in_ch.right_wall_mm    <= driven_tick.right_wall_mm;
          in_ch.random_angle     <= driven_tick.random_angle;
          in_ch.random_side      <= driven_tick.random_side;
          in_ch.valid            <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each command beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        mode_seen[out_ch.mode]++;
        if (expected_cmds.size() == 0) begin
          $error("unexpected command beat: linear %0d angular %0d mode %0d",
                 out_ch.linear_mm_s, out_ch.angular_mrad_s, out_ch.mode);
          err_count++;
        end else begin
          drive_cmd_t exp_cmd;
          exp_cmd = expected_cmds.pop_front();
          if (out_ch.linear_mm_s !== exp_cmd.linear_mm_s) begin
            $error("linear_mm_s: expected %0d, got %0d", exp_cmd.linear_mm_s,
                   out_ch.linear_mm_s);
            err_count++;
          end
          if (out_ch.angular_mrad_s !== exp_cmd.angular_mrad_s) begin
            $error("angular_mrad_s: expected %0d, got %0d", exp_cmd.angular_mrad_s,
                   out_ch.angular_mrad_s);
            err_count++;
          end
          if (out_ch.mode !== exp_cmd.mode) begin
            $error("mode: expected %0d, got %0d", exp_cmd.mode, out_ch.mode);
            err_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    tick_t t;
    // known levels on every input from time zero
    rst_n                  = 1'b0;
    cfg_psel               = 1'b0;
    cfg_penable            = 1'b0;
    cfg_pwrite             = 1'b0;
    cfg_paddr              = '0;
    cfg_pwdata             = '0;
    in_ch.valid            = 1'b0;
    in_ch.bump_side_left   = 1'b0;
    in_ch.bump_side_right  = 1'b0;
    in_ch.bump_fore_left   = 1'b0;
    in_ch.bump_fore_right  = 1'b0;
    in_ch.bump_fore_center = 1'b0;
    in_ch.heading          = '0;
    in_ch.front_min_mm     = '0;
    in_ch.left_side_mm     = '0;
    in_ch.right_side_mm    = '0;
    in_ch.right_wall_mm    = '0;
    in_ch.random_angle     = '0;
    in_ch.random_side      = 1'b0;
    out_ch.ready           = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    err_count       = 0;
    ticks_sent      = 0;
    cycle_count     = 0;
    gen_heading     = '0;
    model_state     = ctl_reset();
    lookahead_state = ctl_reset();
    model_cfg       = '{desired_wall_mm: 12'd600, wall_gain_q8: 10'd205,
                        wall_detect_mm: 13'd1000, obstacle_mm: 13'd500,
                        reverse_ticks: 8'd5, run_ticks: 16'd4800,
                        yaw_tolerance: 15'd1043};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: one-tick reverses keep each case short
    write_reg(REG_REVERSE_TICKS, 1);
    lookahead_state = model_state;
    t = quiet_tick(16'h0000);
    add_tick(t);
    // wall touching, then just inside detect range
    t.right_wall_mm = 16'd0;
    add_tick(t);
    t.right_wall_mm = 16'd999;
    add_tick(t);
    // obstacle with the left side nearer: turn right
    t = quiet_tick(16'h7fff);
    t.front_min_mm  = 16'd0;
    t.left_side_mm  = 16'd100;
    t.right_side_mm = 16'd200;
    t.random_angle  = 16'hffff;
    add_tick(t);
    // heading half a circle off the target, then just inside tolerance
    add_tick(quiet_tick(lookahead_state.target_heading ^ 16'h8000));
    add_tick(quiet_tick(lookahead_state.target_heading + 16'd1042));
    // obstacle with both sides missing: turn left
    t = quiet_tick(16'h8000);
    t.front_min_mm = 16'd499;
    add_tick(t);
    // exactly at tolerance keeps turning, on target ends it
    add_tick(quiet_tick(lookahead_state.target_heading - 16'd1043));
    add_tick(quiet_tick(lookahead_state.target_heading));
    // each bumper alone: bump, reverse end with turn, turn end
    for (int k = 0; k < 5; k++) begin
      t = quiet_tick(16'($urandom));
      t.bumps         = 5'd1 << k;
      t.random_angle  = 16'($urandom);
      t.left_side_mm  = 16'd10;
      t.right_side_mm = 16'd20;
      add_tick(t);
      t.bumps = '0;
      add_tick(t);
      add_tick(quiet_tick(lookahead_state.target_heading));
    end
    // all bumpers, then a second press while reversing
    t = quiet_tick(16'h1234);
    t.bumps        = 5'h1f;
    t.random_angle = 16'd10;
    add_tick(t);
    add_tick(t);
    add_tick(quiet_tick(lookahead_state.target_heading));
    drain();

    // random phases across settings and handshake pressure
    configure(600, 205, 1000, 500, 5, 65535, 1043);
    run_phase(150, 0, 0);
    configure(4000, 1023, 8191, 0, 0, 65535, 0);
    run_phase(150, 73, 0);
    configure(0, 700, 4000, 8000, 255, 65535, 16384);
    run_phase(200, 0, 73);
    configure(4095, 1023, 8000, 1500, 3, int'(model_state.tick_count) + 60, 32767);
    run_phase(150, 32, 32);
    // raising the limit again must not release the halt
    write_reg(REG_RUN_TICKS, 65535);
    run_phase(100, 0, 0);

    if (expected_cmds.size() != 0) begin
      $error("%0d drive commands never arrived", expected_cmds.size());
      err_count++;
    end
    $display("%0d ticks over six setups, idle and stall pressure on both sides", ticks_sent);
    $display("commands seen: %0d forward, %0d reversing, %0d turning, %0d halted",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
